/* rtl/core/sscr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sscr_pkg
// Types and constants shared by the SMI and sleep control register block.
// ----------------------------------------------------------------------------
package sscr_pkg;

   localparam int unsigned SmiByteCount  = 4;
   localparam int unsigned TrapByteCount = 2;

   typedef enum logic [3:0] {
      OP_SMI_WRITE   = 4'd0,
      OP_SMI_READ    = 4'd1,
      OP_PM1_WRITE   = 4'd2,
      OP_PM1_READ    = 4'd3,
      OP_APM_WRITE   = 4'd4,
      OP_KBC_ACCESS  = 4'd5,
      OP_TIMER_OVF   = 4'd6,
      OP_TRAP_WRITE  = 4'd7,
      OP_TRAP_READ   = 4'd8
   } opcode_type;

   typedef enum logic {
      CSR_SMI_LOCK     = 1'b0,
      CSR_TIMER_EVT_EN = 1'b1
   } csr_index_type;

   // Bits of SMI enable/status byte 0.
   localparam int unsigned GblSmiEnBit = 0;
   localparam int unsigned BiosEnBit   = 2;
   localparam int unsigned SlpSmiEnBit = 4;
   localparam int unsigned ApmcEnBit   = 5;
   localparam int unsigned BiosRlsBit  = 7;

   // Bits of PM1 control.
   localparam int unsigned SciEnBit    = 0;
   localparam int unsigned GblRlsBit   = 2;
   localparam int unsigned SlpTypLsb   = 10;
   localparam int unsigned SlpEnBit    = 13;

   localparam int unsigned KbcTrapBit  = 4;

   localparam logic [15:0] Pm1ResetValue = 16'h0001;
   localparam logic [7:0]  KbcReadValue  = 8'hFF;
   localparam logic [2:0]  SlpTypFirst   = 3'd5;
   localparam logic [2:0]  SlpTypBase    = 3'd4;

   typedef struct packed {
      logic [7:0] read_data;
      logic       smi_pulse;
      logic       sci_update;
      logic       set_global_release_status;
      logic [1:0] sleep_request;
      logic       kbc_trap_on;
   } result_type;

endpackage
`default_nettype wire

/* rtl/core/smi_and_sleep_control_registers.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smi_and_sleep_control_registers
// SMI enable/status bytes, PM1 control, trap bytes and the SMI/sleep/SCI
// event logic behind them.
// ----------------------------------------------------------------------------
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the single output register decouples the
// two channels, and an item is taken whenever that register is empty or drains.
// Reset: synchronous; sets the SMI, PM1, trap and CSR registers to their reset
// values (PM1 control to SCI_EN set) and empties the output register.
module smi_and_sleep_control_registers
   import sscr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [3:0] req_opcode,
   input  wire logic [2:0] req_offset,
   input  wire logic [7:0] req_data,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_smi_pulse,
   output logic            rsp_sci_update,
   output logic            rsp_set_global_release_status,
   output logic [1:0]      rsp_sleep_request,
   output logic            rsp_kbc_trap_on,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic       csr_wdata
);

   logic [7:0]  smi_en_ff   [SmiByteCount];
   logic [7:0]  smi_en_in   [SmiByteCount];
   logic [7:0]  smi_sts_ff  [SmiByteCount];
   logic [7:0]  smi_sts_in  [SmiByteCount];
   logic [15:0] pm1_ff, pm1_in;
   logic [7:0]  trap_ff     [TrapByteCount];
   logic [7:0]  trap_in     [TrapByteCount];
   logic        smi_lock_ff, smi_lock_in;
   logic        timer_en_ff, timer_en_in;

   result_type  rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        req_accept;
   logic        smi_req;
   logic [2:0]  slp_typ;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      smi_lock_in = smi_lock_ff;
      timer_en_in = timer_en_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SMI_LOCK:     smi_lock_in = csr_wdata;
            CSR_TIMER_EVT_EN: timer_en_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_comb begin
      smi_en_in  = smi_en_ff;
      smi_sts_in = smi_sts_ff;
      pm1_in     = pm1_ff;
      trap_in    = trap_ff;
      smi_req    = 1'b0;
      slp_typ    = '0;
      rsp_in     = '0;

      case (opcode_type'(req_opcode))
         OP_SMI_WRITE: begin
            if (!req_offset[2]) begin
               smi_en_in[req_offset[1:0]] = req_data;
            end else begin
               smi_sts_in[req_offset[1:0]] = smi_sts_ff[req_offset[1:0]] & req_data;
            end
            // BIOS release is a write-one strobe that clears itself.
            if (smi_en_in[0][BiosRlsBit]) begin
               rsp_in.set_global_release_status = 1'b1;
               rsp_in.sci_update                = 1'b1;
            end
            smi_en_in[0][BiosRlsBit] = 1'b0;
         end
         OP_SMI_READ: begin
            rsp_in.read_data = req_offset[2] ? smi_sts_ff[req_offset[1:0]]
                                             : smi_en_ff[req_offset[1:0]];
         end
         OP_PM1_WRITE: begin
            if (req_offset[0]) begin
               pm1_in[15:8] = req_data;
            end else begin
               pm1_in[7:0] = req_data;
            end
            slp_typ = pm1_in[SlpTypLsb +: 3];
            if (pm1_in[SlpEnBit]) begin
               if (smi_en_ff[0][SlpSmiEnBit]) begin
                  smi_sts_in[0][SlpSmiEnBit] = 1'b1;
                  smi_req = 1'b1;
               end else if (slp_typ >= SlpTypFirst) begin
                  rsp_in.sleep_request = 2'(slp_typ - SlpTypBase);
               end
            end
            if (pm1_in[GblRlsBit] && smi_en_ff[0][BiosEnBit]) begin
               smi_sts_in[0][BiosEnBit] = 1'b1;
               smi_req = 1'b1;
            end
         end
         OP_PM1_READ: begin
            rsp_in.read_data = req_offset[0] ? pm1_ff[15:8] : pm1_ff[7:0];
         end
         OP_APM_WRITE: begin
            if (smi_en_ff[0][ApmcEnBit]) begin
               smi_sts_in[0][ApmcEnBit] = 1'b1;
               smi_req = 1'b1;
            end
         end
         OP_KBC_ACCESS: begin
            rsp_in.read_data = KbcReadValue;
            smi_req = trap_ff[1][KbcTrapBit];
         end
         OP_TIMER_OVF: begin
            if (timer_en_ff) begin
               if (pm1_ff[SciEnBit]) begin
                  rsp_in.sci_update = 1'b1;
               end else begin
                  smi_req = 1'b1;
               end
            end
         end
         OP_TRAP_WRITE: begin
            trap_in[req_offset[0]] = req_data;
         end
         OP_TRAP_READ: begin
            rsp_in.read_data = trap_ff[req_offset[0]];
         end
         default: ;
      endcase

      rsp_in.smi_pulse   = smi_req & smi_en_ff[0][GblSmiEnBit] & ~smi_lock_ff;
      rsp_in.kbc_trap_on = trap_in[1][KbcTrapBit];
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SmiByteCount; i++) begin
            smi_en_ff[i]  <= '0;
            smi_sts_ff[i] <= '0;
         end
         for (int i = 0; i < TrapByteCount; i++) begin
            trap_ff[i] <= '0;
         end
         pm1_ff       <= Pm1ResetValue;
         smi_lock_ff  <= 1'b0;
         timer_en_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         smi_lock_ff  <= smi_lock_in;
         timer_en_ff  <= timer_en_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            smi_en_ff  <= smi_en_in;
            smi_sts_ff <= smi_sts_in;
            pm1_ff     <= pm1_in;
            trap_ff    <= trap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid                     = rsp_valid_ff;
   assign rsp_read_data                 = rsp_ff.read_data;
   assign rsp_smi_pulse                 = rsp_ff.smi_pulse;
   assign rsp_sci_update                = rsp_ff.sci_update;
   assign rsp_set_global_release_status = rsp_ff.set_global_release_status;
   assign rsp_sleep_request             = rsp_ff.sleep_request;
   assign rsp_kbc_trap_on               = rsp_ff.kbc_trap_on;

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// SMI and sleep control register block testbench
// Sends byte accesses and events through the request channel and checks every
// response against a predictor that tracks the SMI enable and status bytes,
// PM1 control and the trap bytes. The run starts with a directed sequence. It
// then goes through random phases under different lock and timer settings,
// with random gaps and stalls on both channels, except in the no-idle phases.
// ----------------------------------------------------------------------------
module tb;
   import sscr_pkg::*;

   localparam logic [3:0] OpUnusedFirst = 4'd9;
   localparam logic [3:0] OpUnusedLast  = 4'd15;
   localparam int unsigned PhaseCount = 6;
   localparam int unsigned PhaseItems = 200;

   typedef struct packed {
      logic [3:0] opcode;
      logic [2:0] offset;
      logic [7:0] data;
   } pm_access_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_opcode = '0;
   logic [2:0] req_offset = '0;
   logic [7:0] req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_smi_pulse;
   logic       rsp_sci_update;
   logic       rsp_set_global_release_status;
   logic [1:0] rsp_sleep_request;
   logic       rsp_kbc_trap_on;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic       csr_wdata = 1'b0;

   // Predictor copy of the block's registers.
   logic        smi_lock_copy;
   logic        timer_enable_copy;
   logic [7:0]  smi_enable_copy [SmiByteCount];
   logic [7:0]  smi_status_copy [SmiByteCount];
   logic [15:0] pm1_control_copy;
   logic [7:0]  trap_copy [TrapByteCount];

   pm_access_type access_queue [$];
   result_type    pending_results [$];
   int unsigned   mismatch_count = 0;
   int unsigned   hold_off = 0;
   int unsigned   stall_left = 0;
   logic          no_idle = 1'b0;

   smi_and_sleep_control_registers uut (
      .clock                         (clock),
      .reset                         (reset),
      .req_valid                     (req_valid),
      .req_stall                     (req_stall),
      .req_opcode                    (req_opcode),
      .req_offset                    (req_offset),
      .req_data                      (req_data),
      .rsp_valid                     (rsp_valid),
      .rsp_stall                     (rsp_stall),
      .rsp_read_data                 (rsp_read_data),
      .rsp_smi_pulse                 (rsp_smi_pulse),
      .rsp_sci_update                (rsp_sci_update),
      .rsp_set_global_release_status (rsp_set_global_release_status),
      .rsp_sleep_request             (rsp_sleep_request),
      .rsp_kbc_trap_on               (rsp_kbc_trap_on),
      .csr_valid                     (csr_valid),
      .csr_ready                     (csr_ready),
      .csr_index                     (csr_index),
      .csr_wdata                     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

   // Applies one access to the register copy and returns the response it causes.
   function automatic result_type apply_access(input pm_access_type a);
      result_type r;
      logic       smi_request;
      logic [2:0] sleep_type;
      r = '0;
      smi_request = 1'b0;
      case (a.opcode)
         OP_SMI_WRITE: begin
            if (a.offset < 3'd4) smi_enable_copy[a.offset[1:0]] = a.data;
            else smi_status_copy[a.offset[1:0]] &= a.data;
            if (smi_enable_copy[0][BiosRlsBit]) begin
               r.set_global_release_status = 1'b1;
               r.sci_update = 1'b1;
            end
            smi_enable_copy[0][BiosRlsBit] = 1'b0;
         end
         OP_SMI_READ: begin
            r.read_data = (a.offset < 3'd4) ? smi_enable_copy[a.offset[1:0]]
                                            : smi_status_copy[a.offset[1:0]];
         end
         OP_PM1_WRITE: begin
            if (a.offset[0]) pm1_control_copy[15:8] = a.data;
            else pm1_control_copy[7:0] = a.data;
            if (pm1_control_copy[SlpEnBit]) begin
               if (smi_enable_copy[0][SlpSmiEnBit]) begin
                  smi_status_copy[0][SlpSmiEnBit] = 1'b1;
                  smi_request = 1'b1;
               end else begin
                  sleep_type = pm1_control_copy[SlpTypLsb +: 3];
                  if (sleep_type >= SlpTypFirst) r.sleep_request = 2'(sleep_type - SlpTypBase);
               end
            end
            if (pm1_control_copy[GblRlsBit] && smi_enable_copy[0][BiosEnBit]) begin
               smi_status_copy[0][BiosEnBit] = 1'b1;
               smi_request = 1'b1;
            end
         end
         OP_PM1_READ: begin
            r.read_data = a.offset[0] ? pm1_control_copy[15:8] : pm1_control_copy[7:0];
         end
         OP_APM_WRITE: begin
            if (smi_enable_copy[0][ApmcEnBit]) begin
               smi_status_copy[0][ApmcEnBit] = 1'b1;
               smi_request = 1'b1;
            end
         end
         OP_KBC_ACCESS: begin
            r.read_data = KbcReadValue;
            if (trap_copy[1][KbcTrapBit]) smi_request = 1'b1;
         end
         OP_TIMER_OVF: begin
            if (timer_enable_copy) begin
               if (pm1_control_copy[SciEnBit]) r.sci_update = 1'b1;
               else smi_request = 1'b1;
            end
         end
         OP_TRAP_WRITE: trap_copy[a.offset[0]] = a.data;
         OP_TRAP_READ: r.read_data = trap_copy[a.offset[0]];
         default: ;
      endcase
      r.smi_pulse = smi_request && smi_enable_copy[0][GblSmiEnBit] && !smi_lock_copy;
      r.kbc_trap_on = trap_copy[1][KbcTrapBit];
      return r;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Request driver: takes items from the queue, with a random gap after each unless no_idle is set.
   always @(posedge clock) begin : access_driver
      pm_access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         hold_off <= 0;
      end else begin
         if (req_valid && !req_stall)
            pending_results.push_back(apply_access({req_opcode, req_offset, req_data}));
         if (!req_valid || !req_stall) begin
            if (hold_off != 0) begin
               req_valid <= 1'b0;
               hold_off <= hold_off - 1;
            end else if (access_queue.size() != 0) begin
               nxt = access_queue.pop_front();
               req_valid <= 1'b1;
               req_opcode <= nxt.opcode;
               req_offset <= nxt.offset;
               req_data <= nxt.data;
               hold_off <= no_idle ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted item and draws a stall after it.
   always @(posedge clock) begin : result_monitor
      result_type  want;
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response item arrived with nothing outstanding");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               compare_field("rsp_read_data", 32'(want.read_data), 32'(rsp_read_data));
               compare_field("rsp_smi_pulse", 32'(want.smi_pulse), 32'(rsp_smi_pulse));
               compare_field("rsp_sci_update", 32'(want.sci_update), 32'(rsp_sci_update));
               compare_field("rsp_set_global_release_status",
                             32'(want.set_global_release_status),
                             32'(rsp_set_global_release_status));
               compare_field("rsp_sleep_request", 32'(want.sleep_request),
                             32'(rsp_sleep_request));
               compare_field("rsp_kbc_trap_on", 32'(want.kbc_trap_on),
                             32'(rsp_kbc_trap_on));
            end
            n = no_idle ? 0 : $urandom_range(0, 3);
            stall_left <= n;
            rsp_stall <= (n != 0);
         end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
         end else begin
            stall_left <= 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SMI_LOCK) smi_lock_copy = value;
      else timer_enable_copy = value;
   endtask

   task automatic queue_access(input logic [3:0] op, input logic [2:0] off,
                               input logic [7:0] value);
      access_queue.push_back('{opcode: op, offset: off, data: value});
   endtask

   // Returns once every queued item has been sent and answered.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (access_queue.size() != 0 || req_valid || pending_results.size() != 0);
   endtask

   initial begin : stimulus
      pm_access_type a;
      int unsigned   pick;
      logic          lock_plan [PhaseCount];
      logic          timer_plan [PhaseCount];
      lock_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      timer_plan = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      smi_lock_copy = 1'b0;
      timer_enable_copy = 1'b0;
      foreach (smi_enable_copy[i]) smi_enable_copy[i] = '0;
      foreach (smi_status_copy[i]) smi_status_copy[i] = '0;
      foreach (trap_copy[i]) trap_copy[i] = '0;
      pm1_control_copy = Pm1ResetValue;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_SMI_LOCK, 1'b0);
      write_csr(CSR_TIMER_EVT_EN, 1'b1);
      @(negedge clock);
      queue_access(OP_PM1_READ, 3'd0, 8'h00);
      queue_access(OP_PM1_READ, 3'd1, 8'h00);
      queue_access(OP_TIMER_OVF, 3'd0, 8'h00);
      // Setting BIOS release must report global release and then clear itself.
      queue_access(OP_SMI_WRITE, 3'd0, 8'hFF);
      queue_access(OP_SMI_WRITE, 3'd3, 8'hFF);
      queue_access(OP_SMI_READ, 3'd0, 8'h00);
      queue_access(OP_SMI_READ, 3'd3, 8'h00);
      queue_access(OP_APM_WRITE, 3'd0, 8'h00);
      queue_access(OP_SMI_READ, 3'd4, 8'h00);
      queue_access(OP_SMI_WRITE, 3'd4, 8'h00);
      // Sleep enable with sleep SMI enabled raises an SMI instead of a request.
      queue_access(OP_PM1_WRITE, 3'd3, 8'h34);
      queue_access(OP_SMI_WRITE, 3'd0, 8'h05);
      queue_access(OP_PM1_WRITE, 3'd1, 8'h34);
      queue_access(OP_PM1_WRITE, 3'd1, 8'h38);
      queue_access(OP_PM1_WRITE, 3'd1, 8'h3C);
      queue_access(OP_PM1_WRITE, 3'd1, 8'h30);
      // Global release with SCI_EN cleared; the timer then goes to SMI.
      queue_access(OP_PM1_WRITE, 3'd6, 8'h04);
      queue_access(OP_TIMER_OVF, 3'd0, 8'h00);
      queue_access(OP_TRAP_WRITE, 3'd3, 8'h10);
      queue_access(OP_KBC_ACCESS, 3'd0, 8'h00);
      queue_access(OP_TRAP_READ, 3'd1, 8'h00);
      queue_access(OP_TRAP_WRITE, 3'd0, 8'hFF);
      queue_access(OP_TRAP_READ, 3'd6, 8'h00);
      queue_access(OP_PM1_WRITE, 3'd7, 8'hFF);
      queue_access(OP_PM1_READ, 3'd7, 8'h00);
      queue_access(OpUnusedFirst, 3'd7, 8'hFF);
      queue_access(OpUnusedLast, 3'd0, 8'h00);
      wait_for_drain();

      for (int p = 0; p < PhaseCount; p++) begin
         write_csr(CSR_SMI_LOCK, lock_plan[p]);
         write_csr(CSR_TIMER_EVT_EN, timer_plan[p]);
         @(negedge clock);
         no_idle = (p % 3 == 1);
         for (int k = 0; k < PhaseItems; k++) begin
            pick = $urandom_range(0, 99);
            a.offset = 3'($urandom_range(0, 7));
            a.data = 8'($urandom_range(0, 255));
            if (pick < 15) begin
               a.opcode = OP_SMI_WRITE;
               // Keep the global SMI enable set more often than not.
               if (a.offset == 3'd0 && $urandom_range(0, 1)) a.data[GblSmiEnBit] = 1'b1;
            end else if (pick < 25) begin
               a.opcode = OP_SMI_READ;
            end else if (pick < 40) begin
               a.opcode = OP_PM1_WRITE;
               if (a.offset[0] && $urandom_range(0, 1)) a.data[SlpEnBit - 8] = 1'b1;
            end else if (pick < 48) begin
               a.opcode = OP_PM1_READ;
            end else if (pick < 58) begin
               a.opcode = OP_APM_WRITE;
            end else if (pick < 68) begin
               a.opcode = OP_KBC_ACCESS;
            end else if (pick < 78) begin
               a.opcode = OP_TIMER_OVF;
            end else if (pick < 88) begin
               a.opcode = OP_TRAP_WRITE;
               if (a.offset[0] && $urandom_range(0, 1)) a.data[KbcTrapBit] = 1'b1;
            end else if (pick < 96) begin
               a.opcode = OP_TRAP_READ;
            end else begin
               a.opcode = 4'($urandom_range(OpUnusedFirst, OpUnusedLast));
            end
            access_queue.push_back(a);
         end
         wait_for_drain();
      end

      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d response items never arrived", pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
